// File: sv/pfavs_pkg.sv
// pfavs_pkg: types, constants and codes for the page frame allocator.
// Shared by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package pfavs_pkg;

    localparam int NUM_FRAMES_DEF = 16;
    localparam int NUM_PROCS      = 4;
    localparam int NUM_PAGES      = 16;

    localparam logic [4:0] FIRST_DATA_PAGE_RST = 5'd2;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_FREE    = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    localparam logic [2:0] ST_ALLOC_FREE  = 3'd0;
    localparam logic [2:0] ST_ALLOC_EVICT = 3'd1;
    localparam logic [2:0] ST_NO_FRAME    = 3'd2;
    localparam logic [2:0] ST_FREED       = 3'd3;
    localparam logic [2:0] ST_IGNORED     = 3'd4;
    localparam logic [2:0] ST_RELEASED    = 3'd5;

    localparam logic [1:0] SCAN_FREE    = 2'd0;
    localparam logic [1:0] SCAN_VICTIM  = 2'd1;
    localparam logic [1:0] SCAN_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] proc;
        logic [3:0] page;
        logic       allow_own;
        logic [3:0] frame;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] frame_out;
        logic       evicted;
        logic [1:0] victim_proc;
        logic [3:0] victim_page;
        logic [3:0] freed_count;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       scan_run;
        logic [1:0] kind;
        logic       want_same;
        logic       want_data;
        logic       set_status;
        logic       alloc;
        logic       evict;
        logic       release_hit;
        logic       do_free;
        logic       out_load;
        logic [2:0] status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       alloc_ok;
        logic       free_ok;
        logic       rel_ok;
        logic       allow_same;
        logic       ev_valid;
        logic       ev_hit;
        logic       ev_last;
        logic       out_free;
    } ctl_stat_t;

endpackage

// File: sv/pfavs_ctrl.sv
// pfavs_ctrl: sequencer for dispatch, free-frame scan, victim passes and release scan.
// Depends on pfavs_pkg; drives the datapath through ctl_cmd_t / ctl_stat_t.
`timescale 1ns / 1ps

module pfavs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output pfavs_pkg::ctl_cmd_t  cmd,
    input  pfavs_pkg::ctl_stat_t stat
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_FSCAN    = 3'd2;
    localparam logic [2:0] S_VSCAN    = 3'd3;
    localparam logic [2:0] S_RSCAN    = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] pass_reg;
    logic [1:0] pass_next;
    logic       last_pass;

    assign in_ready  = (state_reg == S_IDLE);
    assign last_pass = (pass_reg == 2'd3) || ((pass_reg == 2'd2) && !stat.allow_same);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next     = S_FINISH;
                cmd.set_status = 1'b1;
                case (stat.mode)
                    pfavs_pkg::MODE_ALLOC:
                    begin
                        cmd.status = pfavs_pkg::ST_NO_FRAME;
                        if (stat.alloc_ok)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_FSCAN;
                        end
                    end
                    pfavs_pkg::MODE_FREE:
                    begin
                        cmd.status  = stat.free_ok ? pfavs_pkg::ST_FREED
                                                   : pfavs_pkg::ST_IGNORED;
                        cmd.do_free = stat.free_ok;
                    end
                    pfavs_pkg::MODE_RELEASE:
                    begin
                        cmd.status = pfavs_pkg::ST_RELEASED;
                        if (stat.rel_ok)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_RSCAN;
                        end
                    end
                    default:
                    begin
                        cmd.status = pfavs_pkg::ST_IGNORED;
                    end
                endcase
            end
            S_FSCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.kind     = pfavs_pkg::SCAN_FREE;
                cmd.status   = pfavs_pkg::ST_ALLOC_FREE;
                if (stat.ev_valid && stat.ev_hit)
                begin
                    cmd.alloc  = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.ev_valid && stat.ev_last)
                begin
                    cmd.scan_start = 1'b1;
                    pass_next      = 2'd0;
                    state_next     = S_VSCAN;
                end
            end
            S_VSCAN:
            begin
                cmd.scan_run  = 1'b1;
                cmd.kind      = pfavs_pkg::SCAN_VICTIM;
                cmd.want_same = pass_reg[0];
                cmd.want_data = !pass_reg[1];
                cmd.status    = pfavs_pkg::ST_ALLOC_EVICT;
                if (stat.ev_valid && stat.ev_hit)
                begin
                    cmd.alloc  = 1'b1;
                    cmd.evict  = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.ev_valid && stat.ev_last)
                begin
                    if (last_pass)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = pfavs_pkg::ST_NO_FRAME;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        pass_next      = stat.allow_same ? pass_reg + 2'd1 : pass_reg + 2'd2;
                    end
                end
            end
            S_RSCAN:
            begin
                cmd.scan_run    = 1'b1;
                cmd.kind        = pfavs_pkg::SCAN_RELEASE;
                cmd.release_hit = stat.ev_valid && stat.ev_hit;
                if (stat.ev_valid && stat.ev_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    // scans only run for requests that passed the range checks
    a_scan_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISPATCH && cmd.scan_start) |->
            ((stat.mode == pfavs_pkg::MODE_ALLOC && stat.alloc_ok) ||
             (stat.mode == pfavs_pkg::MODE_RELEASE && stat.rel_ok)))
        else $error("scan started for a rejected request");

    a_no_same_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VSCAN && !stat.allow_same) |-> !pass_reg[0])
        else $error("own-process pass entered without permission");

endmodule

// File: sv/pfavs_dp.sv
// pfavs_dp: frame tables, owner memory, scan pipeline, result and output registers.
// Depends on pfavs_pkg; controlled by pfavs_ctrl.
`timescale 1ns / 1ps

module pfavs_dp
#(
    parameter int NUM_FRAMES = pfavs_pkg::NUM_FRAMES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata,
    input  pfavs_pkg::req_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pfavs_pkg::rsp_t      out_data,
    input  pfavs_pkg::ctl_cmd_t  cmd,
    output pfavs_pkg::ctl_stat_t stat
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int IW = FW + 1;

    logic [4:0]            fdp_reg;
    pfavs_pkg::req_t       req_reg;
    logic [NUM_FRAMES-1:0] frame_used_reg;
    logic [NUM_FRAMES-1:0] frame_used_next;
    logic [NUM_FRAMES-1:0] owner_valid_reg;
    logic [NUM_FRAMES-1:0] owner_valid_next;
    logic [1:0]            owner_proc_mem [NUM_FRAMES];
    logic [3:0]            owner_page_mem [NUM_FRAMES];
    logic [IW-1:0]         scan_idx_reg;
    logic                  rd_valid_reg;
    logic [FW-1:0]         rd_idx_reg;
    logic [1:0]            rd_proc_reg;
    logic [3:0]            rd_page_reg;
    pfavs_pkg::rsp_t       res_reg;
    pfavs_pkg::rsp_t       res_clr;
    logic                  out_valid_reg;
    pfavs_pkg::rsp_t       out_reg;

    logic          issue;
    logic [FW-1:0] free_idx;
    logic          proc_match;
    logic          same_page;
    logic          is_data;
    logic          hit;

    assign issue      = cmd.scan_run && (scan_idx_reg < IW'(NUM_FRAMES));
    assign free_idx   = FW'(req_reg.frame);
    assign proc_match = (rd_proc_reg == req_reg.proc);
    assign same_page  = (rd_page_reg == req_reg.page);
    assign is_data    = ({1'b0, rd_page_reg} >= fdp_reg);

    always_comb
    begin
        case (cmd.kind)
            pfavs_pkg::SCAN_FREE:
                hit = !frame_used_reg[rd_idx_reg];
            pfavs_pkg::SCAN_VICTIM:
                hit = owner_valid_reg[rd_idx_reg] && !(proc_match && same_page) &&
                      (proc_match == cmd.want_same) && (is_data == cmd.want_data);
            pfavs_pkg::SCAN_RELEASE:
                hit = owner_valid_reg[rd_idx_reg] && proc_match;
            default:
                hit = 1'b0;
        endcase
    end

    always_comb
    begin
        stat            = '0;
        stat.mode       = req_reg.mode;
        stat.alloc_ok   = (32'(req_reg.proc) < pfavs_pkg::NUM_PROCS) &&
                          (32'(req_reg.page) < pfavs_pkg::NUM_PAGES);
        stat.free_ok    = (req_reg.frame != 4'd0) && (32'(req_reg.frame) < NUM_FRAMES) &&
                          frame_used_reg[free_idx];
        stat.rel_ok     = (32'(req_reg.proc) < pfavs_pkg::NUM_PROCS);
        stat.allow_same = req_reg.allow_own;
        stat.ev_valid   = rd_valid_reg;
        stat.ev_hit     = hit;
        stat.ev_last    = (rd_idx_reg == FW'(NUM_FRAMES - 1));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        res_clr        = '0;
        res_clr.status = cmd.status;
    end

    always_comb
    begin
        frame_used_next  = frame_used_reg;
        owner_valid_next = owner_valid_reg;
        if (cmd.alloc)
        begin
            frame_used_next[rd_idx_reg]  = 1'b1;
            owner_valid_next[rd_idx_reg] = 1'b1;
        end
        else if (cmd.release_hit)
        begin
            frame_used_next[rd_idx_reg]  = 1'b0;
            owner_valid_next[rd_idx_reg] = 1'b0;
        end
        else if (cmd.do_free)
        begin
            frame_used_next[free_idx]  = 1'b0;
            owner_valid_next[free_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdp_reg         <= pfavs_pkg::FIRST_DATA_PAGE_RST;
            frame_used_reg  <= NUM_FRAMES'(1);
            owner_valid_reg <= '0;
            scan_idx_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fdp_reg <= cfg_wdata;
            end
            frame_used_reg  <= frame_used_next;
            owner_valid_reg <= owner_valid_next;
            if (cmd.scan_start)
            begin
                scan_idx_reg <= IW'(1);
                rd_valid_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + IW'(1);
                end
                rd_valid_reg <= issue;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // owner memory: one write port at the evaluated entry, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            owner_proc_mem[rd_idx_reg] <= req_reg.proc;
            owner_page_mem[rd_idx_reg] <= req_reg.page;
        end
        if (issue)
        begin
            rd_idx_reg  <= scan_idx_reg[FW-1:0];
            rd_proc_reg <= owner_proc_mem[scan_idx_reg[FW-1:0]];
            rd_page_reg <= owner_page_mem[scan_idx_reg[FW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
        if (cmd.set_status)
        begin
            res_reg <= res_clr;
        end
        else if (cmd.alloc)
        begin
            res_reg.status      <= cmd.status;
            res_reg.frame_out   <= 4'(rd_idx_reg);
            res_reg.evicted     <= cmd.evict;
            res_reg.victim_proc <= cmd.evict ? rd_proc_reg : 2'd0;
            res_reg.victim_page <= cmd.evict ? rd_page_reg : 4'd0;
            res_reg.freed_count <= 4'd0;
        end
        else if (cmd.release_hit)
        begin
            res_reg.freed_count <= res_reg.freed_count + 4'd1;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_frame0_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        frame_used_reg[0])
        else $error("frame 0 lost its reservation");

    a_owner_implies_used: assert property (@(posedge clk) disable iff (!rst_n)
        (owner_valid_reg & ~frame_used_reg) == '0)
        else $error("owned frame marked unused");

    a_evict_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.evicted == (out_reg.status == pfavs_pkg::ST_ALLOC_EVICT)))
        else $error("eviction flag disagrees with status");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending transaction");

endmodule

// File: sv/page_frame_allocator_victim_select.sv
// Allocate runs a free-frame scan and, if no frame is free, victim passes; release runs a
// release scan; free, ignored and rejected transactions run no scan. Scans step one frame
// per cycle through the owner memory read port.
// One transaction in flight; the next is accepted once the result is in the output register.
// Reset (rst_n async, active low): frame 0 reserved, all other frames free and unowned,
// data page base = 2, no pending result. Owner memory contents are not reset.
`timescale 1ns / 1ps

module page_frame_allocator_victim_select
#(
    parameter int NUM_FRAMES = pfavs_pkg::NUM_FRAMES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [4:0]      cfg_wdata,
    input  logic            in_valid,
    output logic            in_ready,
    input  pfavs_pkg::req_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output pfavs_pkg::rsp_t out_data
);

    pfavs_pkg::ctl_cmd_t  cmd;
    pfavs_pkg::ctl_stat_t stat;

    pfavs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pfavs_dp
    #(
        .NUM_FRAMES (NUM_FRAMES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
